/* design/asma_pkg.sv */
// shared types, constants and microcode table of the adc sample moving average
package asma_pkg;

    // fixed field widths
    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 12;
    localparam int SVOLT_W = 15;
    localparam int MEAN_W  = 23;

    // mean numerator is total * 1280 (5 * 256), needs this many extra bits
    localparam int SCALE_W = 11;

    // divider iteration counter
    localparam int ITER_W  = $clog2(MEAN_W + 1);

    typedef struct packed {
        logic [BYTE_W-1:0] high_byte;
        logic [BYTE_W-1:0] low_byte;
    } t_in;

    typedef struct packed {
        logic [CODE_W-1:0]  sample_code;
        logic [SVOLT_W-1:0] sample_volts;
        logic [MEAN_W-1:0]  mean_volts;
        logic               window_full;
    } t_out;

    // microprogram step addresses
    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] t_step;

    localparam t_step STEP_WAIT = 3'd0;
    localparam t_step STEP_SUB  = 3'd1;
    localparam t_step STEP_ADD  = 3'd2;
    localparam t_step STEP_LOAD = 3'd3;
    localparam t_step STEP_DIV  = 3'd4;
    localparam t_step STEP_EMIT = 3'd5;

    // jump conditions
    typedef enum logic [1:0] {
        COND_NEVER,
        COND_NO_INPUT,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } t_cond;

    // one control word
    typedef struct packed {
        logic  accept;
        logic  sub_old;
        logic  add_new;
        logic  div_load;
        logic  div_step;
        logic  emit;
        t_cond cond;
        t_step target;
        logic  wrap;
    } t_ctrl;

    // status back from the datapath
    typedef struct packed {
        logic in_valid;
        logic div_busy;
        logic out_busy;
    } t_status;

    localparam t_ctrl CTRL_NOP = '{
        accept: 1'b0, sub_old: 1'b0, add_new: 1'b0, div_load: 1'b0,
        div_step: 1'b0, emit: 1'b0, cond: COND_NEVER, target: STEP_WAIT,
        wrap: 1'b1
    };

    // microcode rom
    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        w = CTRL_NOP;
        case (step)
            STEP_WAIT: begin
                w.accept = 1'b1;
                w.cond   = COND_NO_INPUT;
                w.target = STEP_WAIT;
                w.wrap   = 1'b0;
            end
            STEP_SUB: begin
                w.sub_old = 1'b1;
                w.wrap    = 1'b0;
            end
            STEP_ADD: begin
                w.add_new = 1'b1;
                w.wrap    = 1'b0;
            end
            STEP_LOAD: begin
                w.div_load = 1'b1;
                w.wrap     = 1'b0;
            end
            STEP_DIV: begin
                w.div_step = 1'b1;
                w.cond     = COND_DIV_BUSY;
                w.target   = STEP_DIV;
                w.wrap     = 1'b0;
            end
            STEP_EMIT: begin
                w.emit   = 1'b1;
                w.cond   = COND_OUT_BUSY;
                w.target = STEP_EMIT;
                w.wrap   = 1'b1;
            end
            default: begin
                w = CTRL_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

/* design/adc_sample_moving_average.sv */
// top level of the adc sample moving average
// Moving average of 12-bit converter readings. Each input transfer carries the two
// data bytes of one reading; the code is the low nibble of high_byte over low_byte.
// The code goes into a ring of the last WINDOW samples (a small ram) and a running
// total is kept. Each input gives exactly one result: the code, the sample voltage
// 5*code in units of 1/4096 V, the mean over the held samples floor(5*256*total/count)
// in units of 1/1048576 V (count is the number of samples held, at most WINDOW, and
// includes this sample), and a flag set once WINDOW samples have been stored.
// Control is a six-step microprogram: accept, subtract the oldest code, add the new
// code and write the ring, load the divider, 23 restoring divide steps, emit. The
// divider forms one quotient bit per cycle. A new reading is taken only once the
// sequencer has left the emit step and is back in its wait step. The result sits in an
// output register, so the next input transfer is taken while it waits; the
// sequencer holds in its emit step only if the previous result has not been taken.
// The ring contents need no clearing after reset: only slots already written are read.
module adc_sample_moving_average #(
    parameter int WINDOW = 20
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  asma_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output asma_pkg::t_out o_out_data
);

    // control word of the current step and status fed back for jumps
    asma_pkg::t_ctrl   ctrl;
    asma_pkg::t_status status;

    asma_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    // ring, total, count and divider all live in the datapath
    asma_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // input transfer only in the wait step of the microprogram
    assign o_in_ready = ctrl.accept;

endmodule

/* design/asma_ram.sv */
// generic single write port ram with registered read
module asma_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 20,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/asma_seq.sv */
// microcode sequencer: step counter, control rom and conditional jumps
module asma_seq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  asma_pkg::t_status i_status,
    output asma_pkg::t_ctrl  o_ctrl
);

    asma_pkg::t_step r_step;
    asma_pkg::t_step n_step;
    asma_pkg::t_ctrl ctrl;
    logic            cond_true;

    assign ctrl = asma_pkg::ucode(r_step);

    always_comb begin
        case (ctrl.cond)
            asma_pkg::COND_NEVER:    cond_true = 1'b0;
            asma_pkg::COND_NO_INPUT: cond_true = !i_status.in_valid;
            asma_pkg::COND_DIV_BUSY: cond_true = i_status.div_busy;
            asma_pkg::COND_OUT_BUSY: cond_true = i_status.out_busy;
            default:                 cond_true = 1'b0;
        endcase
    end

    always_comb begin
        if (cond_true) begin
            n_step = ctrl.target;
        end else if (ctrl.wrap) begin
            n_step = asma_pkg::STEP_WAIT;
        end else begin
            n_step = r_step + asma_pkg::t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= asma_pkg::STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = ctrl;

endmodule

/* design/asma_dp.sv */
// datapath: sample ring, running total, count, restoring divider, output register
module asma_dp #(
    parameter int WINDOW = 20,
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1,
    localparam int CNT_W   = $clog2(WINDOW + 1),
    localparam int TOTAL_W = asma_pkg::CODE_W + CNT_W,
    localparam int NUM_W   = TOTAL_W + asma_pkg::SCALE_W
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  asma_pkg::t_ctrl   i_ctrl,
    input  logic              i_in_valid,
    input  asma_pkg::t_in     i_in_data,
    input  logic              i_out_ready,
    output asma_pkg::t_status o_status,
    output logic              o_out_valid,
    output asma_pkg::t_out    o_out_data
);

    localparam int QW = asma_pkg::MEAN_W;

    logic [asma_pkg::CODE_W-1:0] r_code;
    logic [SLOT_W-1:0]           r_slot;
    logic                        r_full;
    logic [CNT_W-1:0]            r_count;
    logic [TOTAL_W-1:0]          r_total;
    logic [CNT_W-1:0]            r_rem;
    logic [QW-1:0]               r_quo;
    logic [CNT_W-1:0]            r_div;
    logic [asma_pkg::ITER_W-1:0] r_iter;
    asma_pkg::t_out              r_out;
    logic                        r_out_valid;

    logic [asma_pkg::CODE_W-1:0] old_code;
    logic                        accept_go;
    logic                        emit_go;
    logic                        out_busy;
    logic [NUM_W-1:0]            num;
    logic [CNT_W:0]              shifted;
    logic [CNT_W:0]              diff;
    logic                        fits;

    assign out_busy  = r_out_valid && !i_out_ready;
    assign accept_go = i_ctrl.accept && i_in_valid;
    assign emit_go   = i_ctrl.emit && !out_busy;

    asma_ram #(
        .WIDTH (asma_pkg::CODE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.add_new),
        .i_waddr (r_slot),
        .i_wdata (r_code),
        .i_raddr (r_slot),
        .o_rdata (old_code)
    );

    // total * 1280 as two shifted copies
    assign num = NUM_W'({r_total, 10'b0}) + NUM_W'({r_total, 8'b0});

    // one restoring division step
    assign shifted = {r_rem, r_quo[QW-1]};
    assign diff    = shifted - {1'b0, r_div};
    assign fits    = shifted >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot      <= '0;
            r_full      <= 1'b0;
            r_count     <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctrl.sub_old && r_full) begin
                r_total <= r_total - TOTAL_W'(old_code);
            end
            if (i_ctrl.add_new) begin
                r_total <= r_total + TOTAL_W'(r_code);
                if (r_slot == SLOT_W'(WINDOW - 1)) begin
                    r_slot <= '0;
                    r_full <= 1'b1;
                end else begin
                    r_slot <= r_slot + SLOT_W'(1);
                end
                if (r_count != CNT_W'(WINDOW)) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_go) begin
            r_code <= {i_in_data.high_byte[3:0], i_in_data.low_byte};
        end
        if (i_ctrl.div_load) begin
            r_rem  <= num[NUM_W-1:QW];
            r_quo  <= num[QW-1:0];
            r_div  <= r_count;
            r_iter <= asma_pkg::ITER_W'(QW);
        end
        if (i_ctrl.div_step) begin
            r_rem  <= fits ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            r_quo  <= {r_quo[QW-2:0], fits};
            r_iter <= r_iter - asma_pkg::ITER_W'(1);
        end
        if (emit_go) begin
            r_out.sample_code  <= r_code;
            r_out.sample_volts <= {1'b0, r_code, 2'b0} + asma_pkg::SVOLT_W'(r_code);
            r_out.mean_volts   <= r_quo;
            r_out.window_full  <= r_full;
        end
    end

    assign o_status.in_valid = i_in_valid;
    assign o_status.div_busy = (r_iter != asma_pkg::ITER_W'(1));
    assign o_status.out_busy = out_busy;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* test/tb.sv */
// testbench for the adc sample moving average: directed and random readings checked live
`timescale 1ns / 100ps

module tb;

    // ring depth of the block under test
    localparam int WINDOW = 20;
    // cycle budget, several times the slowest legal run
    localparam int CYCLE_LIMIT = 800000;
    // random readings after the directed part
    localparam int RANDOM_READINGS = 650;

    // running-mean predictor and store of pending results
    class mean_scoreboard;
        logic [asma_pkg::CODE_W-1:0] ring_codes [WINDOW];
        int unsigned                 next_slot;
        int unsigned                 held;
        int unsigned                 code_total;
        bit                          filled;
        asma_pkg::t_out              pending_results [$];
        int                          errors;

        function new();
            next_slot  = 0;
            held       = 0;
            code_total = 0;
            filled     = 1'b0;
            errors     = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // work out the result of one accepted reading
        function void note_input(asma_pkg::t_in reading);
            logic [asma_pkg::CODE_W-1:0] code;
            int unsigned                 divisor;
            int unsigned                 numer;
            asma_pkg::t_out              res;
            code = {reading.high_byte[3:0], reading.low_byte};
            // oldest sample leaves the total once the ring has wrapped
            if (filled) begin
                code_total = code_total - ring_codes[next_slot];
            end
            ring_codes[next_slot] = code;
            code_total = code_total + code;
            next_slot = next_slot + 1;
            if (next_slot >= WINDOW) begin
                next_slot = 0;
                filled    = 1'b1;
            end
            if (held < WINDOW) begin
                held = held + 1;
            end
            divisor = filled ? WINDOW : held;
            numer   = code_total * 1280;
            res.sample_code  = code;
            res.sample_volts = asma_pkg::SVOLT_W'(code * 5);
            res.mean_volts   = (divisor != 0) ? asma_pkg::MEAN_W'(numer / divisor) : '0;
            res.window_full  = filled;
            pending_results.push_back(res);
        endfunction

        // compare one accepted result with the oldest pending one
        function void check_result(asma_pkg::t_out got);
            asma_pkg::t_out want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors = errors + 1;
                return;
            end
            want = pending_results.pop_front();
            if (got.sample_code !== want.sample_code) begin
                $display("%0t: sample_code expected %0d actual %0d",
                         $time, want.sample_code, got.sample_code);
                errors = errors + 1;
            end
            if (got.sample_volts !== want.sample_volts) begin
                $display("%0t: sample_volts expected %0d actual %0d",
                         $time, want.sample_volts, got.sample_volts);
                errors = errors + 1;
            end
            if (got.mean_volts !== want.mean_volts) begin
                $display("%0t: mean_volts expected %0d actual %0d",
                         $time, want.mean_volts, got.mean_volts);
                errors = errors + 1;
            end
            if (got.window_full !== want.window_full) begin
                $display("%0t: window_full expected %0d actual %0d",
                         $time, want.window_full, got.window_full);
                errors = errors + 1;
            end
        endfunction
    endclass

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic           o_in_ready;
    asma_pkg::t_in  i_in_data   = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    asma_pkg::t_out o_out_data;

    mean_scoreboard sb = new();
    int cycles = 0;
    // readings still to go with no input gaps
    int input_calm = 0;
    // output stall state
    int ready_hold = 0;
    int ready_calm = 0;

    adc_sample_moving_average #(
        .WINDOW(WINDOW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // 20 ns clock
    always #10 i_clk = ~i_clk;

    // hard stop if the run hangs
    always @(posedge i_clk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // output side: mostly short stalls, a few long ones, and stretches with none
    always @(posedge i_clk) begin
        int pick;
        if (ready_hold > 0) begin
            i_out_ready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (ready_calm > 0) begin
                ready_calm = ready_calm - 1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick >= 94) begin
                    ready_calm = $urandom_range(50, 400);
                end else if (pick >= 88) begin
                    ready_hold = $urandom_range(20, 90);
                end else if (pick >= 60) begin
                    ready_hold = $urandom_range(1, 3);
                end
            end
        end
    end

    // every result transfer is checked against the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out_data);
        end
    end

    // idle cycles before the next reading: mostly none or short, a few long
    function automatic int input_gap();
        int pick;
        if (input_calm > 0) begin
            input_calm = input_calm - 1;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 85) return $urandom_range(1, 4);
        if (pick < 93) return $urandom_range(20, 100);
        input_calm = $urandom_range(20, 80);
        return 0;
    endfunction

    // offer one reading, hold it until the transfer, then idle for gap cycles;
    // valid stays high across a zero gap so it is never dropped and raised in one step
    task automatic send_reading(input asma_pkg::t_in reading, input int gap);
        i_in_valid <= 1'b1;
        i_in_data  <= reading;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        sb.note_input(reading);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            i_in_data  <= asma_pkg::t_in'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop sending until every pending result has been taken
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // random reading, biased toward the code extremes now and then
    function automatic asma_pkg::t_in random_reading();
        asma_pkg::t_in r;
        int            pick;
        r    = asma_pkg::t_in'($urandom);
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            r.high_byte[3:0] = 4'hf;
            r.low_byte       = 8'hff;
        end else if (pick == 1) begin
            r.high_byte[3:0] = 4'h0;
            r.low_byte       = 8'h00;
        end
        return r;
    endfunction

    initial begin
        asma_pkg::t_in directed [$];
        int            k;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero code, all bits set, upper nibble alone, lower bits alone,
        // alternating patterns
        directed.push_back(asma_pkg::t_in'{high_byte: 8'h00, low_byte: 8'h00});
        directed.push_back(asma_pkg::t_in'{high_byte: 8'hff, low_byte: 8'hff});
        directed.push_back(asma_pkg::t_in'{high_byte: 8'hf0, low_byte: 8'h00});
        directed.push_back(asma_pkg::t_in'{high_byte: 8'h0f, low_byte: 8'hff});
        directed.push_back(asma_pkg::t_in'{high_byte: 8'ha5, low_byte: 8'h5a});
        directed.push_back(asma_pkg::t_in'{high_byte: 8'h5a, low_byte: 8'ha5});
        // full-scale codes fill the ring, wrap the slot and raise the total to nineteen
        // full-scale codes and one other, so the oldest samples get replaced
        for (k = 0; k < 19; k++) begin
            directed.push_back(asma_pkg::t_in'{high_byte: 8'h3f, low_byte: 8'hff});
        end
        foreach (directed[i]) begin
            send_reading(directed[i], (i % 3 == 0) ? 2 : 0);
        end
        drain();

        // random readings, pausing for a full drain now and then
        for (k = 0; k < RANDOM_READINGS; k++) begin
            send_reading(random_reading(), input_gap());
            if (k % 160 == 159) begin
                drain();
            end
        end

        drain();
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
